// ===== hw/rtl/line_pixel_generator_top_macros.svh =====
// assertion macros for the line pixel generator checker
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef LINE_PIXEL_GENERATOR_TOP_MACROS_SVH
`define LINE_PIXEL_GENERATOR_TOP_MACROS_SVH

// same-cycle or explicitly delayed property, off while in reset
`define LPG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define LPG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/lpg_pkg.sv =====
// shared types and codes for the line pixel generator
// no dependencies
`default_nettype none

package lpg_pkg;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    typedef enum logic [1:0] {
        MODE_SINGLE  = 2'd0,
        MODE_HORIZ   = 2'd1,
        MODE_VERT    = 2'd2,
        MODE_GENERAL = 2'd3
    } t_mode;

    typedef struct packed {
        logic  active;
        t_mode mode;
        logic  x_neg;
        logic  y_neg;
        logic  inner;
    } t_ctrl;

endpackage

`default_nettype wire

// ===== hw/rtl/lpg_setup.sv =====
// line setup: distances, step directions, mode and starting error
// depends on lpg_pkg
`default_nettype none

module lpg_setup
    import lpg_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  wire logic [COORD_BITS-1:0] i_start_x,
    input  wire logic [COORD_BITS-1:0] i_start_y,
    input  wire logic [COORD_BITS-1:0] i_end_x,
    input  wire logic [COORD_BITS-1:0] i_end_y,
    output t_ctrl                      o_ctrl,
    output logic [COORD_BITS-1:0]      o_x_dist,
    output logic [COORD_BITS-1:0]      o_y_dist,
    output logic signed [COORD_BITS+1:0] o_err
);

    logic signed [COORD_BITS:0] dx;
    logic signed [COORD_BITS:0] dy;
    logic [COORD_BITS:0]        dx_abs;
    logic [COORD_BITS:0]        dy_abs;
    logic [COORD_BITS:0]        xd_plus;
    logic [COORD_BITS-1:0]      half;

    always_comb begin
        dx = $signed({i_end_x[COORD_BITS-1], i_end_x})
           - $signed({i_start_x[COORD_BITS-1], i_start_x});
        dy = $signed({i_end_y[COORD_BITS-1], i_end_y})
           - $signed({i_start_y[COORD_BITS-1], i_start_y});
        dx_abs = dx[COORD_BITS] ? $unsigned(-dx) : $unsigned(dx);
        dy_abs = dy[COORD_BITS] ? $unsigned(-dy) : $unsigned(dy);
        o_x_dist = dx_abs[COORD_BITS-1:0];
        o_y_dist = dy_abs[COORD_BITS-1:0];

        // rounded half of the x distance, negated
        xd_plus = {1'b0, o_x_dist} + {{COORD_BITS{1'b0}}, 1'b1};
        half    = xd_plus[COORD_BITS:1];
        o_err   = -$signed({2'b00, half});

        o_ctrl.active = 1'b1;
        o_ctrl.x_neg  = dx[COORD_BITS];
        o_ctrl.y_neg  = dy[COORD_BITS];
        o_ctrl.inner  = 1'b0;
        if (dx == '0 && dy == '0) begin
            o_ctrl.mode = MODE_SINGLE;
        end else if (dy == '0) begin
            o_ctrl.mode = MODE_HORIZ;
        end else if (dx == '0) begin
            o_ctrl.mode = MODE_VERT;
        end else begin
            o_ctrl.mode = MODE_GENERAL;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/lpg_step.sv =====
// one pixel step of the rasterizer: next coordinates, error and end flag
// depends on lpg_pkg
`default_nettype none

module lpg_step
    import lpg_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  wire t_ctrl                   i_ctrl,
    input  wire logic [COORD_BITS-1:0]   i_cur_x,
    input  wire logic [COORD_BITS-1:0]   i_cur_y,
    input  wire logic [COORD_BITS-1:0]   i_tgt_x,
    input  wire logic [COORD_BITS-1:0]   i_tgt_y,
    input  wire logic [COORD_BITS-1:0]   i_x_dist,
    input  wire logic [COORD_BITS-1:0]   i_y_dist,
    input  wire logic signed [COORD_BITS+1:0] i_err,
    output t_ctrl                        o_ctrl,
    output logic [COORD_BITS-1:0]        o_cur_x,
    output logic [COORD_BITS-1:0]        o_cur_y,
    output logic signed [COORD_BITS+1:0] o_err,
    output logic                         o_done
);

    localparam logic [COORD_BITS-1:0] ONE = {{(COORD_BITS-1){1'b0}}, 1'b1};

    logic [COORD_BITS-1:0]        step_x;
    logic [COORD_BITS-1:0]        step_y;
    logic signed [COORD_BITS+1:0] err_upd;

    always_comb begin
        step_x = i_ctrl.x_neg ? i_cur_x - ONE : i_cur_x + ONE;
        step_y = i_ctrl.y_neg ? i_cur_y - ONE : i_cur_y + ONE;
        err_upd = i_ctrl.inner ? i_err - $signed({2'b00, i_x_dist})
                               : i_err + $signed({2'b00, i_y_dist});

        o_ctrl  = i_ctrl;
        o_cur_x = i_cur_x;
        o_cur_y = i_cur_y;
        o_err   = i_err;
        o_done  = 1'b0;

        case (i_ctrl.mode)
            MODE_SINGLE: begin
                o_done = 1'b1;
            end
            MODE_HORIZ: begin
                o_cur_x = step_x;
                o_done  = (step_x == i_tgt_x);
            end
            MODE_VERT: begin
                o_cur_y = step_y;
                o_done  = (step_y == i_tgt_y);
            end
            default: begin
                o_err = err_upd;
                if (i_ctrl.inner) begin
                    o_cur_y = step_y;
                end
                // positive error: repeat the pixel and take a y step next
                if (err_upd > 0) begin
                    o_ctrl.inner = 1'b1;
                end else begin
                    o_ctrl.inner = 1'b0;
                    o_cur_x      = step_x;
                    o_done       = (step_x == i_tgt_x);
                end
            end
        endcase

        if (o_done) begin
            o_ctrl.active = 1'b0;
            o_ctrl.inner  = 1'b0;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/line_pixel_generator_top.sv =====
// line pixel generator top level: input register, line state, result register
// depends on lpg_pkg, lpg_setup, lpg_step
//
//  channel | valid   | ready   | word
//  --------+---------+---------+---------------------------------------------
//  input   | i_valid | o_ready | i_command, i_start_x/y, i_end_x/y, i_line_color
//  output  | o_valid | i_ready | o_pixel_x, o_pixel_y, o_pixel_color, o_last_pixel
//
// one word per cycle in, one pixel per cycle out while i_ready stays high; a tick's
// pixel passes the input register, then the result register
// a start word loads the line state and gives no pixel; an idle tick gives none
// the result register stalls on i_ready low; the input register then holds and
// o_ready drops once both are full, so the input side can take one more word
// while one pixel waits
// i_rst_n (synchronous, active low) drops the line and both registers
`default_nettype none

module line_pixel_generator_top
    import lpg_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // input word
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic                  i_command,
    input  wire logic [COORD_BITS-1:0] i_start_x,
    input  wire logic [COORD_BITS-1:0] i_start_y,
    input  wire logic [COORD_BITS-1:0] i_end_x,
    input  wire logic [COORD_BITS-1:0] i_end_y,
    input  wire logic [31:0]           i_line_color,
    // output word
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [COORD_BITS-1:0]      o_pixel_x,
    output logic [COORD_BITS-1:0]      o_pixel_y,
    output logic [31:0]                o_pixel_color,
    output logic                       o_last_pixel
);

    // input register
    logic                  r_in_valid;
    logic                  r_in_cmd;
    logic [COORD_BITS-1:0] r_in_sx;
    logic [COORD_BITS-1:0] r_in_sy;
    logic [COORD_BITS-1:0] r_in_ex;
    logic [COORD_BITS-1:0] r_in_ey;
    logic [31:0]           r_in_color;

    // line state
    t_ctrl                        r_ctrl,  n_ctrl;
    logic [COORD_BITS-1:0]        r_cur_x, n_cur_x;
    logic [COORD_BITS-1:0]        r_cur_y, n_cur_y;
    logic [COORD_BITS-1:0]        r_tgt_x, n_tgt_x;
    logic [COORD_BITS-1:0]        r_tgt_y, n_tgt_y;
    logic [COORD_BITS-1:0]        r_x_dist, n_x_dist;
    logic [COORD_BITS-1:0]        r_y_dist, n_y_dist;
    logic signed [COORD_BITS+1:0] r_err,   n_err;
    logic [31:0]                  r_color, n_color;

    // result register
    logic                  r_out_valid, n_out_valid;
    logic [COORD_BITS-1:0] r_out_x,     n_out_x;
    logic [COORD_BITS-1:0] r_out_y,     n_out_y;
    logic [31:0]           r_out_color, n_out_color;
    logic                  r_out_last,  n_out_last;

    // combinational results of the two units
    t_ctrl                        setup_ctrl;
    logic [COORD_BITS-1:0]        setup_xd;
    logic [COORD_BITS-1:0]        setup_yd;
    logic signed [COORD_BITS+1:0] setup_err;
    t_ctrl                        step_ctrl;
    logic [COORD_BITS-1:0]        step_x;
    logic [COORD_BITS-1:0]        step_y;
    logic signed [COORD_BITS+1:0] step_err;
    logic                         step_done;

    logic advance;
    logic in_take;

    // the stored word moves on whenever the result register is free or draining
    assign advance = !r_out_valid || i_ready;
    assign o_ready = !r_in_valid || advance;
    assign in_take = i_valid && o_ready;

    lpg_setup #(
        .COORD_BITS (COORD_BITS)
    ) u_lpg_setup (
        .i_start_x (r_in_sx),
        .i_start_y (r_in_sy),
        .i_end_x   (r_in_ex),
        .i_end_y   (r_in_ey),
        .o_ctrl    (setup_ctrl),
        .o_x_dist  (setup_xd),
        .o_y_dist  (setup_yd),
        .o_err     (setup_err)
    );

    lpg_step #(
        .COORD_BITS (COORD_BITS)
    ) u_lpg_step (
        .i_ctrl   (r_ctrl),
        .i_cur_x  (r_cur_x),
        .i_cur_y  (r_cur_y),
        .i_tgt_x  (r_tgt_x),
        .i_tgt_y  (r_tgt_y),
        .i_x_dist (r_x_dist),
        .i_y_dist (r_y_dist),
        .i_err    (r_err),
        .o_ctrl   (step_ctrl),
        .o_cur_x  (step_x),
        .o_cur_y  (step_y),
        .o_err    (step_err),
        .o_done   (step_done)
    );

    // next line state and result
    always_comb begin
        n_ctrl      = r_ctrl;
        n_cur_x     = r_cur_x;
        n_cur_y     = r_cur_y;
        n_tgt_x     = r_tgt_x;
        n_tgt_y     = r_tgt_y;
        n_x_dist    = r_x_dist;
        n_y_dist    = r_y_dist;
        n_err       = r_err;
        n_color     = r_color;
        n_out_valid = r_out_valid && !i_ready;
        n_out_x     = r_out_x;
        n_out_y     = r_out_y;
        n_out_color = r_out_color;
        n_out_last  = r_out_last;

        if (r_in_valid && advance) begin
            if (r_in_cmd == CMD_START) begin
                // a new line replaces whatever was running
                n_ctrl   = setup_ctrl;
                n_cur_x  = r_in_sx;
                n_cur_y  = r_in_sy;
                n_tgt_x  = r_in_ex;
                n_tgt_y  = r_in_ey;
                n_x_dist = setup_xd;
                n_y_dist = setup_yd;
                n_err    = setup_err;
                n_color  = r_in_color;
            end else if (r_ctrl.active) begin
                n_ctrl      = step_ctrl;
                n_cur_x     = step_x;
                n_cur_y     = step_y;
                n_err       = step_err;
                n_out_valid = 1'b1;
                n_out_x     = r_cur_x;
                n_out_y     = r_cur_y;
                n_out_color = r_color;
                n_out_last  = step_done;
            end
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_cmd   <= i_command;
            r_in_sx    <= i_start_x;
            r_in_sy    <= i_start_y;
            r_in_ex    <= i_end_x;
            r_in_ey    <= i_end_y;
            r_in_color <= i_line_color;
        end
    end

    // line state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl      <= '{active: 1'b0, mode: MODE_SINGLE, x_neg: 1'b0,
                             y_neg: 1'b0, inner: 1'b0};
            r_out_valid <= 1'b0;
        end else begin
            r_ctrl      <= n_ctrl;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur_x     <= n_cur_x;
        r_cur_y     <= n_cur_y;
        r_tgt_x     <= n_tgt_x;
        r_tgt_y     <= n_tgt_y;
        r_x_dist    <= n_x_dist;
        r_y_dist    <= n_y_dist;
        r_err       <= n_err;
        r_color     <= n_color;
        r_out_x     <= n_out_x;
        r_out_y     <= n_out_y;
        r_out_color <= n_out_color;
        r_out_last  <= n_out_last;
    end

    assign o_valid       = r_out_valid;
    assign o_pixel_x     = r_out_x;
    assign o_pixel_y     = r_out_y;
    assign o_pixel_color = r_out_color;
    assign o_last_pixel  = r_out_last;

endmodule

`default_nettype wire

// ===== hw/rtl/lpg_checker.sv =====
// port-level checks for the line pixel generator, bound to the top level
// depends on lpg_pkg and line_pixel_generator_top_macros.svh
`default_nettype none
`include "line_pixel_generator_top_macros.svh"

module lpg_checker
    import lpg_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_valid,
    input wire logic                  o_ready,
    input wire logic                  i_command,
    input wire logic                  o_valid,
    input wire logic                  i_ready,
    input wire logic [COORD_BITS-1:0] o_pixel_x,
    input wire logic [COORD_BITS-1:0] o_pixel_y
);

    // a waiting pixel holds its coordinates
    `LPG_ASSERT_NEXT(a_hold, o_valid && !i_ready, o_valid && $stable(o_pixel_x) && $stable(o_pixel_y), "pixel changed while stalled")

    // an empty result register never blocks the input side
    `LPG_ASSERT(a_ready_empty, !o_valid |-> o_ready, "input blocked with no pixel pending")

    // a draining pixel frees the input side in the same cycle
    `LPG_ASSERT(a_ready_drain, (o_valid && i_ready) |-> o_ready, "input blocked while pixel drains")

    // a fresh pixel comes from an earlier taken tick
    `LPG_ASSERT(a_from_tick, $rose(o_valid) |-> $past(i_valid && o_ready && (i_command == CMD_TICK), 2), "pixel without a tick")

endmodule

bind line_pixel_generator_top lpg_checker #(
    .COORD_BITS (COORD_BITS)
) u_lpg_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_valid   (i_valid),
    .o_ready   (o_ready),
    .i_command (i_command),
    .o_valid   (o_valid),
    .i_ready   (i_ready),
    .o_pixel_x (o_pixel_x),
    .o_pixel_y (o_pixel_y)
);

`default_nettype wire
